/* rtl/core/sliding_window_rate_meter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rate meter
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_METER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_RATE_METER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define SWRM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("swrm assertion failed");
// Next-cycle implication, checked out of reset
`define SWRM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("swrm assertion failed");
`else
`define SWRM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define SWRM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

/* rtl/core/swrm_pkg.sv */
// ----------------------------------------------------------------------------
// swrm_pkg
// Field widths and fixed constants of the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int TS_W      = 32;   // timestamp_ms
    localparam int WIN_W     = 16;   // window_ms register
    localparam int MASK_W    = 8;    // lane_valid_mask
    localparam int TOTAL_W   = 32;   // total_pieces
    localparam int EV_RATE_W = 20;   // event_rate_tenths
    localparam int PC_RATE_W = 23;   // piece_rate_tenths

    // rate = (amount * 20000 + span) / (2 * span): tenths per second, half up
    localparam int RATE_SCALE = 20000;
    localparam int SCALE_W    = 15;

    localparam logic [WIN_W-1:0]     WINDOW_RESET = 16'd1000;
    localparam logic [EV_RATE_W-1:0] EV_RATE_MAX  = '1;
    localparam logic [PC_RATE_W-1:0] PC_RATE_MAX  = '1;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

endpackage

/* rtl/core/sliding_window_rate_meter_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_rate_meter_top
// Counts valid pieces per event and measures event and piece rates over a
// sliding millisecond window kept in a ring memory.
// ----------------------------------------------------------------------------
// One request is worked at a time. A clear request goes from S_IDLE to S_EMIT
// and back. A record request passes S_FULL (only when the ring is full),
// S_APPEND, S_CHECK, one S_AGE and S_CHECK pass for every ring entry it
// drops, then S_MUL_EV, S_MUL_PC, the S_DIV loop and S_EMIT. When both rates
// come out zero (fewer than two entries left, or no span), it goes from
// S_CHECK or S_AGE straight to S_EMIT. The serial divider works one quotient
// bit per cycle, both rates in parallel; the eviction walk does one ring read
// per dropped entry. The result sits in an output register, so the next
// request is taken while it waits; a result that finds that register still
// stalled holds the block until it frees. The ring memory needs no clearing
// pass: only entries inside the occupied part are read.
// ----------------------------------------------------------------------------
`include "sliding_window_rate_meter_top_defines.svh"

module sliding_window_rate_meter_top
    import swrm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int LANES         = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [WIN_W-1:0]     cfg_wr_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [TS_W-1:0]      timestamp_ms,
    input  logic [MASK_W-1:0]    lane_valid_mask,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TOTAL_W-1:0]   total_pieces,
    output logic [EV_RATE_W-1:0] event_rate_tenths,
    output logic [PC_RATE_W-1:0] piece_rate_tenths
);

    localparam int IDX_W      = $clog2(HISTORY_DEPTH);
    localparam int OCC_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W      = $clog2(LANES + 1);
    localparam int SUM_W      = $clog2(HISTORY_DEPTH * LANES + 1);
    localparam int ENTRY_W    = TS_W + CNT_W;
    localparam int USED_LANES = (LANES < MASK_W) ? LANES : MASK_W;
    localparam int NUM_W      = ((SUM_W + SCALE_W) > TS_W ? (SUM_W + SCALE_W) : TS_W) + 1;
    localparam int DEN_W      = TS_W + 1;
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam logic [MASK_W-1:0] LANE_MASK = MASK_W'((32'd1 << USED_LANES) - 32'd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL,
        S_APPEND,
        S_CHECK,
        S_AGE,
        S_MUL_EV,
        S_MUL_PC,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       oldest_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [WIN_W-1:0]       window_ms_reg;
    logic [DCNT_W-1:0]      div_cnt_reg;
    logic                   out_valid_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic [EV_RATE_W-1:0]   out_ev_reg;
    logic [PC_RATE_W-1:0]   out_pc_reg;

    // datapath registers, no reset
    logic [TS_W-1:0]        now_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [TS_W-1:0]        span_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [NUM_W-1:0]       dq_ev_reg;
    logic [NUM_W-1:0]       dq_pc_reg;
    logic [DEN_W-1:0]       rem_ev_reg;
    logic [DEN_W-1:0]       rem_pc_reg;

    // ring memory: {time, count}
    logic [ENTRY_W-1:0]     ring_mem [HISTORY_DEPTH];
    logic [ENTRY_W-1:0]     mem_rd_data;
    logic                   mem_rd_en;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wr_addr;

    logic                   accept;
    logic                   go_clear;
    logic                   go_record;
    logic [CNT_W-1:0]       cnt_in;
    logic [TOTAL_W:0]       total_sum;
    logic [TOTAL_W-1:0]     total_next;
    logic [IDX_W:0]         pos_sum;
    logic [IDX_W-1:0]       oldest_inc;
    logic [TS_W-1:0]        rd_time;
    logic [CNT_W-1:0]       rd_cnt;
    logic [TS_W-1:0]        age;
    logic                   too_old;
    logic                   zero_rates;
    logic [SUM_W-1:0]       mul_amt;
    logic [NUM_W-1:0]       mul_out;
    logic [DEN_W:0]         rem_sh_ev;
    logic [DEN_W:0]         rem_sh_pc;
    logic [DEN_W:0]         rem_sub_ev;
    logic [DEN_W:0]         rem_sub_pc;
    logic                   ge_ev;
    logic                   ge_pc;
    logic                   div_last;
    logic [EV_RATE_W-1:0]   ev_sat;
    logic [PC_RATE_W-1:0]   pc_sat;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign go_clear  = accept && (action == ACT_CLEAR);
    assign go_record = accept && (action == ACT_RECORD);

    assign cnt_in     = CNT_W'($countones(lane_valid_mask & LANE_MASK));
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(cnt_in);
    assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

    // append slot: oldest + occupancy, wrapped once
    assign pos_sum     = {1'b0, oldest_reg} + (IDX_W + 1)'(occ_reg);
    assign mem_wr_addr = (pos_sum >= (IDX_W + 1)'(HISTORY_DEPTH))
                       ? IDX_W'(pos_sum - (IDX_W + 1)'(HISTORY_DEPTH))
                       : pos_sum[IDX_W-1:0];
    assign oldest_inc  = (oldest_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                       : oldest_reg + 1'b1;

    assign rd_time = mem_rd_data[ENTRY_W-1:CNT_W];
    assign rd_cnt  = mem_rd_data[CNT_W-1:0];
    assign age     = now_reg - rd_time;
    assign too_old = age > TS_W'(window_ms_reg);

    assign mem_rd_en = (state_reg == S_IDLE) || (state_reg == S_CHECK);
    assign mem_we    = (state_reg == S_APPEND);

    assign zero_rates = go_clear
                     || (state_reg == S_CHECK && occ_reg < OCC_W'(2))
                     || (state_reg == S_AGE && !too_old && age == '0);

    // one shared constant multiplier for both numerators
    assign mul_amt = (state_reg == S_MUL_EV) ? SUM_W'(occ_reg) : sum_reg;
    assign mul_out = NUM_W'(mul_amt) * NUM_W'(RATE_SCALE) + NUM_W'(span_reg);

    // restoring division step, both rates side by side
    assign rem_sh_ev  = {rem_ev_reg, dq_ev_reg[NUM_W-1]};
    assign rem_sh_pc  = {rem_pc_reg, dq_pc_reg[NUM_W-1]};
    assign ge_ev      = rem_sh_ev >= {1'b0, den_reg};
    assign ge_pc      = rem_sh_pc >= {1'b0, den_reg};
    assign rem_sub_ev = ge_ev ? rem_sh_ev - {1'b0, den_reg} : rem_sh_ev;
    assign rem_sub_pc = ge_pc ? rem_sh_pc - {1'b0, den_reg} : rem_sh_pc;
    assign div_last   = (div_cnt_reg == DCNT_W'(NUM_W - 1));

    assign ev_sat = (dq_ev_reg > NUM_W'(EV_RATE_MAX)) ? EV_RATE_MAX
                  : dq_ev_reg[EV_RATE_W-1:0];
    assign pc_sat = (dq_pc_reg > NUM_W'(PC_RATE_MAX)) ? PC_RATE_MAX
                  : dq_pc_reg[PC_RATE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_wr_addr] <= {now_reg, cnt_reg};
        end
        if (mem_rd_en)
        begin
            mem_rd_data <= ring_mem[oldest_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_record)
        begin
            now_reg <= timestamp_ms;
            cnt_reg <= cnt_in;
        end
        if (state_reg == S_AGE)
        begin
            span_reg <= age;
            den_reg  <= {age, 1'b0};
        end
        if (zero_rates)
        begin
            dq_ev_reg <= '0;
            dq_pc_reg <= '0;
        end
        else if (state_reg == S_MUL_EV)
        begin
            dq_ev_reg  <= mul_out;
            rem_ev_reg <= '0;
        end
        else if (state_reg == S_MUL_PC)
        begin
            dq_pc_reg  <= mul_out;
            rem_pc_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            dq_ev_reg  <= {dq_ev_reg[NUM_W-2:0], ge_ev};
            dq_pc_reg  <= {dq_pc_reg[NUM_W-2:0], ge_pc};
            rem_ev_reg <= rem_sub_ev[DEN_W-1:0];
            rem_pc_reg <= rem_sub_pc[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            window_ms_reg <= WINDOW_RESET;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_ev_reg    <= '0;
            out_pc_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_ms_reg <= cfg_wr_data;
            end
            // S_EMIT reloads the output register on its own
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (go_clear)
                    begin
                        oldest_reg <= '0;
                        occ_reg    <= '0;
                        sum_reg    <= '0;
                        total_reg  <= '0;
                        state_reg  <= S_EMIT;
                    end
                    else if (go_record)
                    begin
                        total_reg <= total_next;
                        // full ring: the oldest entry is read now and dropped next
                        state_reg <= (occ_reg == OCC_W'(HISTORY_DEPTH)) ? S_FULL : S_APPEND;
                    end
                end
                S_FULL:
                begin
                    sum_reg    <= sum_reg - SUM_W'(rd_cnt);
                    oldest_reg <= oldest_inc;
                    occ_reg    <= occ_reg - 1'b1;
                    state_reg  <= S_APPEND;
                end
                S_APPEND:
                begin
                    occ_reg   <= occ_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'(cnt_reg);
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    // the new entry alone always stays; otherwise read the oldest
                    state_reg <= (occ_reg < OCC_W'(2)) ? S_EMIT : S_AGE;
                end
                S_AGE:
                begin
                    if (too_old)
                    begin
                        sum_reg    <= sum_reg - SUM_W'(rd_cnt);
                        oldest_reg <= oldest_inc;
                        occ_reg    <= occ_reg - 1'b1;
                        state_reg  <= S_CHECK;
                    end
                    else
                    begin
                        state_reg <= (age == '0) ? S_EMIT : S_MUL_EV;
                    end
                end
                S_MUL_EV:
                begin
                    state_reg <= S_MUL_PC;
                end
                S_MUL_PC:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_total_reg <= total_reg;
                        out_ev_reg    <= ev_sat;
                        out_pc_reg    <= pc_sat;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign total_pieces      = out_total_reg;
    assign event_rate_tenths = out_ev_reg;
    assign piece_rate_tenths = out_pc_reg;

    `SWRM_ASSERT_IMPL(a_append_room, clk, rst_n, state_reg == S_APPEND, occ_reg < OCC_W'(HISTORY_DEPTH))
    `SWRM_ASSERT_IMPL(a_age_pair, clk, rst_n, state_reg == S_AGE, occ_reg >= OCC_W'(2))
    `SWRM_ASSERT_NEXT(a_clear_empties, clk, rst_n, go_clear, occ_reg == '0 && sum_reg == '0 && total_reg == '0)

endmodule
